// File: hdl/smf_pkg.sv
// Shared constants, control types and state encoding for the sliding median filter.
`default_nettype none

package smf_pkg;

  localparam int SMF_MAX_RADIUS   = 15;
  localparam int SMF_SAMPLE_BITS  = 16;
  localparam int SMF_CFG_BITS     = 4;
  localparam int SMF_RADIUS_RESET = 1;

  // Sequencer states: wait for a sample, feed the sort chain, hand over a median.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } smf_state_t;

  // Per-cycle command broadcast to every sort cell.
  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctl_t;

  // Status one sort cell passes on to its right-hand neighbour.
  typedef struct packed {
    logic occ;
    logic gt;
  } cell_link_t;

endpackage

`default_nettype wire

// File: hdl/smf_if.sv
// Valid/ready channel interfaces for samples, medians and the radius register.
`default_nettype none

interface smf_in_if
  import smf_pkg::*;
#(
  parameter int SAMPLE_BITS = SMF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_stream;

  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface smf_out_if
  import smf_pkg::*;
#(
  parameter int SAMPLE_BITS = SMF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;
  logic                          final_result;

  modport source (output valid, median, final_result, input ready);
  modport sink   (input valid, median, final_result, output ready);
endinterface

interface smf_cfg_if
  import smf_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SMF_CFG_BITS-1:0] half_width;

  modport source (output valid, half_width, input ready);
  modport sink   (input valid, half_width, output ready);
endinterface

`default_nettype wire

// File: hdl/sliding_median_filter.sv
// Top level of the sliding median filter: sequencer, sample history, sort chain, output register.
//
//   channel | direction | payload                      | transaction
//   in_ch   | sink      | sample, end_of_stream        | valid && ready
//   out_ch  | source    | median, final_result         | valid && ready
//   cfg_ch  | sink      | half_width                   | valid && ready (ready tied high)
//
// An item that yields no median is taken in ST_IDLE alone. For each median of an item
// the sort chain is cleared and refilled one value per cycle with the 2r + 1 window
// values, and the result is then handed to the output register. The single sort chain
// sets this pace: no new sample is taken while medians are being built. A stalled output
// holds the sequencer in its hand-over state; a new sample is taken as soon as the last
// median sits in the output register. Synchronous active-low reset clears control state; no clearing pass is run.
`default_nettype none

module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int MAX_RADIUS  = SMF_MAX_RADIUS,
  parameter int SAMPLE_BITS = SMF_SAMPLE_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  smf_in_if.sink    in_ch,
  smf_out_if.source out_ch,
  smf_cfg_if.sink   cfg_ch
);

  localparam int Depth = 2 * MAX_RADIUS + 1;   // history taps and sort cells
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int RadW  = $clog2(MAX_RADIUS + 1);
  localparam int AgeW  = IdxW + 1;             // signed: ages below zero clamp to newest

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  smf_state_t                    state_r, state_nxt;
  logic [SMF_CFG_BITS-1:0]       radius_cfg_r, radius_cfg_nxt;
  logic                          in_seq_r, in_seq_nxt;
  logic [CntW-1:0]               seen_r, seen_nxt;
  logic signed [SAMPLE_BITS-1:0] first_r, first_nxt;
  logic                          eos_r, eos_nxt;
  logic [RadW-1:0]               rad_r, rad_nxt;
  logic [RadW-1:0]               cen_r, cen_nxt;
  logic signed [AgeW-1:0]        age_r, age_nxt;
  logic [IdxW-1:0]               left_r, left_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_median_r, out_median_nxt;
  logic                          out_final_r, out_final_nxt;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                          in_acc;
  logic                          out_free;
  logic                          out_load;
  logic [RadW-1:0]               rad_eff;
  logic [CntW-1:0]               seen_acc;
  logic [CntW-1:0]               n_acc;
  logic                          long_enough;
  logic [RadW-1:0]               cen_acc;
  logic [RadW-1:0]               cen_dec;
  logic [IdxW-1:0]               age_idx;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic signed [SAMPLE_BITS-1:0] feed_val;
  sort_ctl_t                     sort_ctl;

  logic signed [SAMPLE_BITS-1:0] cell_val  [Depth];
  cell_link_t                    cell_lnk  [Depth];
  logic signed [SAMPLE_BITS-1:0] prev_val  [Depth];
  cell_link_t                    prev_lnk  [Depth];
  logic [Depth-1:0]              occ_vec;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Clamp the programmed radius into 1..MAX_RADIUS.
  always_comb begin
    if (radius_cfg_r == '0) begin
      rad_eff = RadW'(1);
    end else if (int'(radius_cfg_r) > MAX_RADIUS) begin
      rad_eff = RadW'(MAX_RADIUS);
    end else begin
      rad_eff = RadW'(radius_cfg_r);
    end
  end

  // Sample count after the incoming sample; a fresh stream restarts at one.
  always_comb begin
    if (!in_seq_r) begin
      seen_acc = CntW'(1);
    end else if (seen_r == CntW'(Depth)) begin
      seen_acc = seen_r;
    end else begin
      seen_acc = seen_r + CntW'(1);
    end
  end

  // The first median is centred r back once r samples follow it; on a short stream
  // that ends here, start at the oldest available centre instead.
  assign n_acc       = seen_acc - CntW'(1);
  assign long_enough = (n_acc >= CntW'(rad_eff));
  assign cen_acc     = long_enough ? rad_eff : RadW'(n_acc);
  assign cen_dec     = cen_r - RadW'(1);

  // Window value for the current age: newest for ages below zero, first sample for
  // ages beyond the start of the stream, else the history tap.
  assign age_idx  = age_r[AgeW-1] ? '0 : age_r[IdxW-1:0];
  assign feed_val = (CntW'(age_idx) >= seen_r) ? first_r : hist_rd;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    radius_cfg_nxt  = cfg_ch.valid ? cfg_ch.half_width : radius_cfg_r;
    in_seq_nxt      = in_seq_r;
    seen_nxt        = seen_r;
    first_nxt       = first_r;
    eos_nxt         = eos_r;
    rad_nxt         = rad_r;
    cen_nxt         = cen_r;
    age_nxt         = age_r;
    left_nxt        = left_r;
    sort_ctl.clear  = 1'b0;
    sort_ctl.insert = 1'b0;
    out_load        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_seq_r) begin
            first_nxt = in_ch.sample;
          end
          seen_nxt   = seen_acc;
          in_seq_nxt = !in_ch.end_of_stream;
          eos_nxt    = in_ch.end_of_stream;
          rad_nxt    = rad_eff;
          if (long_enough || in_ch.end_of_stream) begin
            cen_nxt        = cen_acc;
            age_nxt        = AgeW'(cen_acc) + AgeW'(rad_eff);
            left_nxt       = IdxW'({rad_eff, 1'b0});
            sort_ctl.clear = 1'b1;
            state_nxt      = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        // Insert one window value per cycle, oldest age first.
        sort_ctl.insert = 1'b1;
        age_nxt         = age_r - AgeW'(1);
        left_nxt        = left_r - IdxW'(1);
        if (left_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // Hold until the output register frees up, then advance to the next centre at end of stream, or return to idle.
        if (out_free) begin
          out_load = 1'b1;
          if (eos_r && (cen_r != '0)) begin
            cen_nxt        = cen_dec;
            age_nxt        = AgeW'(cen_dec) + AgeW'(rad_r);
            left_nxt       = IdxW'({rad_r, 1'b0});
            sort_ctl.clear = 1'b1;
            state_nxt      = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load a median, drop it once taken.
  always_comb begin
    out_median_nxt = out_median_r;
    out_final_nxt  = out_final_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_median_nxt = cell_val[IdxW'(rad_r)];
      out_final_nxt  = eos_r && (cen_r == '0);
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      radius_cfg_r <= SMF_CFG_BITS'(SMF_RADIUS_RESET);
      in_seq_r     <= 1'b0;
      seen_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      radius_cfg_r <= radius_cfg_nxt;
      in_seq_r     <= in_seq_nxt;
      seen_r       <= seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    eos_r        <= eos_nxt;
    rad_r        <= rad_nxt;
    cen_r        <= cen_nxt;
    age_r        <= age_nxt;
    left_r       <= left_nxt;
    out_median_r <= out_median_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.median       = out_median_r;
  assign out_ch.final_result = out_final_r;

  // ---------------------------------------------------------------------------
  // Sample history
  // ---------------------------------------------------------------------------
  smf_history #(
    .W     (SAMPLE_BITS),
    .DEPTH (Depth)
  ) u_history (
    .clk      (clk),
    .shift_en (in_acc),
    .din      (in_ch.sample),
    .rd_idx   (age_idx),
    .rd_data  (hist_rd)
  );

  // ---------------------------------------------------------------------------
  // Sort chain: ascending from cell zero, the median lands in cell r
  // ---------------------------------------------------------------------------
  always_comb begin
    prev_val[0] = '0;
    prev_lnk[0] = '{occ: 1'b1, gt: 1'b0};
    for (int i = 1; i < Depth; i++) begin
      prev_val[i] = cell_val[i-1];
      prev_lnk[i] = cell_lnk[i-1];
    end
    for (int i = 0; i < Depth; i++) begin
      occ_vec[i] = cell_lnk[i].occ;
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    smf_sort_cell #(
      .W (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (sort_ctl),
      .din      (feed_val),
      .prev_val (prev_val[g]),
      .prev_lnk (prev_lnk[g]),
      .val      (cell_val[g]),
      .lnk      (cell_lnk[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_window_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> $countones(occ_vec) == 2 * int'(rad_r) + 1)
    else $error("sort chain does not hold a full window at hand-over");

  a_centre_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && !eos_r |-> cen_r == rad_r)
    else $error("mid-stream median not centred r samples back");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CntW'(Depth))
    else $error("sample count beyond history depth");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_final_nxt |-> !in_seq_r)
    else $error("final median issued while stream still open");

endmodule

`default_nettype wire

// File: hdl/smf_history.sv
// Shift line of recent samples, newest at tap zero, with one indexed read.
`default_nettype none

module smf_history
  import smf_pkg::*;
#(
  parameter int  W     = SMF_SAMPLE_BITS,
  parameter int  DEPTH = 2 * SMF_MAX_RADIUS + 1,
  localparam int IW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                shift_en,
  input  wire logic signed [W-1:0] din,
  input  wire logic [IW-1:0]       rd_idx,
  output      logic signed [W-1:0] rd_data
);

  logic signed [W-1:0] tap_r   [DEPTH];
  logic signed [W-1:0] tap_nxt [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tap_nxt[i] = tap_r[i];
    end
    if (shift_en) begin
      tap_nxt[0] = din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_nxt[i] = tap_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      tap_r[i] <= tap_nxt[i];
    end
  end

  assign rd_data = tap_r[rd_idx];

endmodule

`default_nettype wire

// File: hdl/smf_sort_cell.sv
// One cell of the insertion sort chain: keep, take the new value or take the left value.
`default_nettype none

module smf_sort_cell
  import smf_pkg::*;
#(
  parameter int W = SMF_SAMPLE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sort_ctl_t           ctl,
  input  wire logic signed [W-1:0] din,
  input  wire logic signed [W-1:0] prev_val,
  input  wire cell_link_t          prev_lnk,
  output      logic signed [W-1:0] val,
  output      cell_link_t          lnk
);

  logic signed [W-1:0] val_r, val_nxt;
  logic                occ_r, occ_nxt;
  logic                gt;

  // An empty cell counts as greater than anything.
  assign gt = !occ_r || (val_r > din);

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctl.clear) begin
      occ_nxt = 1'b0;
    end else if (ctl.insert && gt) begin
      if (prev_lnk.gt) begin
        val_nxt = prev_val;
        occ_nxt = prev_lnk.occ;
      end else begin
        val_nxt = din;
        occ_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val     = val_r;
  assign lnk.occ = occ_r;
  assign lnk.gt  = gt;

endmodule

`default_nettype wire
